@@ sv/kbc_pkg.sv @@
// Shared types and constants for the keyed blit clipping filter.
`timescale 1ns / 1ps
package kbc_pkg;

  localparam int CoordW = 16;
  localparam int PixW   = 32;
  localparam int RgbW   = 24;
  localparam int AddrW  = 5;
  localparam int DataW  = 32;

  typedef enum logic [2:0] {
    RegSourceSize  = 3'd0,
    RegTargetSize  = 3'd1,
    RegRectOrigin  = 3'd2,
    RegRectExtent  = 3'd3,
    RegPlaceOrigin = 3'd4,
    RegColorKey    = 3'd5,
    RegKeyEnable   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [31:0]     source_size;
    logic [31:0]     target_size;
    logic [31:0]     rect_origin;
    logic [31:0]     rect_extent;
    logic [31:0]     place_origin;
    logic [RgbW-1:0] color_key;
    logic            key_enable;
  } cfg_t;

  typedef struct packed {
    logic              hit;
    logic [CoordW-1:0] dst;
  } axis_res_t;

endpackage

@@ sv/kbc_if.sv @@
// Pixel input and result output stream interfaces.
`timescale 1ns / 1ps
interface kbc_in_if;
  import kbc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] src_x;
  logic [CoordW-1:0] src_y;
  logic [PixW-1:0]   pixel;
  modport source(output valid, src_x, src_y, pixel, input ready);
  modport sink(input valid, src_x, src_y, pixel, output ready);
endinterface

interface kbc_out_if;
  import kbc_pkg::*;
  logic              valid;
  logic              ready;
  logic              in_region;
  logic              write_enable;
  logic [CoordW-1:0] dst_x;
  logic [CoordW-1:0] dst_y;
  logic [PixW-1:0]   pixel_out;
  modport source(output valid, in_region, write_enable, dst_x, dst_y, pixel_out,
                 input ready);
  modport sink(input valid, in_region, write_enable, dst_x, dst_y, pixel_out,
               output ready);
endinterface

@@ sv/keyed_blit_with_clipping_top.sv @@
// Keyed blit write filter: source/destination rectangle clipping and color key.
// Three register stages lie between an input transfer and the earliest output transfer.
// Throughput: one pixel per cycle while out_o.ready holds; the three stages are source clip,
// destination clip, and region test with coordinate mapping.
// Stalls back up through the stage enables without losing or repeating items.
// Reset clears the valid bits and all configuration registers to zero.
`timescale 1ns / 1ps
module keyed_blit_with_clipping_top #(
  parameter int COORD_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  kbc_in_if.sink                     in_i,
  kbc_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kbc_pkg::AddrW-1:0]  paddr,
  input  logic [kbc_pkg::DataW-1:0]  pwdata,
  output logic [kbc_pkg::DataW-1:0]  prdata,
  output logic                       pready
);
  import kbc_pkg::*;

  cfg_t            cfg;
  axis_res_t       res_x, res_y;
  logic [2:0]      en;
  logic            v1_q, v2_q, v3_q;
  logic            km1_q, km2_q, km3_q;
  logic [PixW-1:0] pix1_q, pix2_q, pix3_q;
  logic            region;

  kbc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // a stage loads when it is empty or its contents move on
  assign en[2]    = !v3_q || out_o.ready;
  assign en[1]    = !v2_q || en[2];
  assign en[0]    = !v1_q || en[1];
  assign in_i.ready = en[0];

  kbc_axis_pipe #(.CoordBits(COORD_BITS)) u_axis_x (
    .clk_i      (clk_i),
    .en_i       (en),
    .origin_i   (cfg.rect_origin[15:0]),
    .extent_i   (cfg.rect_extent[15:0]),
    .place_i    (cfg.place_origin[15:0]),
    .src_size_i (cfg.source_size[15:0]),
    .dst_size_i (cfg.target_size[15:0]),
    .coord_i    (in_i.src_x),
    .res_o      (res_x)
  );

  kbc_axis_pipe #(.CoordBits(COORD_BITS)) u_axis_y (
    .clk_i      (clk_i),
    .en_i       (en),
    .origin_i   (cfg.rect_origin[31:16]),
    .extent_i   (cfg.rect_extent[31:16]),
    .place_i    (cfg.place_origin[31:16]),
    .src_size_i (cfg.source_size[31:16]),
    .dst_size_i (cfg.target_size[31:16]),
    .coord_i    (in_i.src_y),
    .res_o      (res_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en[0]) v1_q <= in_i.valid;
      if (en[1]) v2_q <= v1_q;
      if (en[2]) v3_q <= v2_q;
    end
  end

  // key match is taken on entry and carried with the pixel
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      pix1_q <= in_i.pixel;
      km1_q  <= cfg.key_enable && (in_i.pixel[RgbW-1:0] == cfg.color_key);
    end
    if (en[1]) begin
      pix2_q <= pix1_q;
      km2_q  <= km1_q;
    end
    if (en[2]) begin
      pix3_q <= pix2_q;
      km3_q  <= km2_q;
    end
  end

  assign region             = res_x.hit && res_y.hit;
  assign out_o.valid        = v3_q;
  assign out_o.in_region    = region;
  assign out_o.write_enable = region && !km3_q;
  assign out_o.dst_x        = region ? res_x.dst : '0;
  assign out_o.dst_y        = region ? res_y.dst : '0;
  assign out_o.pixel_out    = pix3_q;

endmodule

@@ sv/kbc_regs.sv @@
// APB register file holding the blit geometry and color key.
`timescale 1ns / 1ps
module kbc_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kbc_pkg::AddrW-1:0]  paddr,
  input  logic [kbc_pkg::DataW-1:0]  pwdata,
  output logic [kbc_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output kbc_pkg::cfg_t              cfg_o
);
  import kbc_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegSourceSize:  cfg_d.source_size  = pwdata;
        RegTargetSize:  cfg_d.target_size  = pwdata;
        RegRectOrigin:  cfg_d.rect_origin  = pwdata;
        RegRectExtent:  cfg_d.rect_extent  = pwdata;
        RegPlaceOrigin: cfg_d.place_origin = pwdata;
        RegColorKey:    cfg_d.color_key    = pwdata[RgbW-1:0];
        RegKeyEnable:   cfg_d.key_enable   = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegSourceSize:  prdata = cfg_q.source_size;
      RegTargetSize:  prdata = cfg_q.target_size;
      RegRectOrigin:  prdata = cfg_q.rect_origin;
      RegRectExtent:  prdata = cfg_q.rect_extent;
      RegPlaceOrigin: prdata = cfg_q.place_origin;
      RegColorKey:    prdata = DataW'(cfg_q.color_key);
      RegKeyEnable:   prdata = DataW'(cfg_q.key_enable);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ sv/kbc_axis_pipe.sv @@
// Three-stage clip and map pipeline for one coordinate axis.
`timescale 1ns / 1ps
module kbc_axis_pipe #(
  parameter int CoordBits = 16
) (
  input  logic                        clk_i,
  input  logic [2:0]                  en_i,
  input  logic [kbc_pkg::CoordW-1:0]  origin_i,
  input  logic [kbc_pkg::CoordW-1:0]  extent_i,
  input  logic [kbc_pkg::CoordW-1:0]  place_i,
  input  logic [kbc_pkg::CoordW-1:0]  src_size_i,
  input  logic [kbc_pkg::CoordW-1:0]  dst_size_i,
  input  logic [kbc_pkg::CoordW-1:0]  coord_i,
  output kbc_pkg::axis_res_t          res_o
);
  import kbc_pkg::*;

  localparam int W = CoordBits + 3;

  // stage 1: clip the source rectangle to the source surface
  logic signed [W-1:0] s0, w0, srcsz, s1, w1, w2, sum1;
  logic signed [W-1:0] s1_q, w1_q, p1_q;
  logic                ok1_q;

  // stage 2: place on the destination and clip, shrinking the source edge
  logic signed [W-1:0] d0, dstsz, s2, dw1, d1, dw2, sum2;
  logic signed [W-1:0] s2_q, dw2_q, d2_q, p2_q;
  logic                ok2_q;

  // stage 3: region test and destination coordinate
  logic signed [W-1:0] end3, ofs3;
  logic                hit3;
  axis_res_t           res_q;

  always_comb begin
    s0    = W'(signed'(origin_i[CoordBits-1:0]));
    w0    = W'(signed'(extent_i[CoordBits-1:0]));
    srcsz = W'(src_size_i[CoordBits-1:0]);
    if (s0 < 0) begin
      s1 = '0;
      w1 = w0 + s0;
    end else begin
      s1 = s0;
      w1 = w0;
    end
    sum1 = s1 + w1;
    w2   = (sum1 > srcsz) ? srcsz - s1 : w1;
  end

  always_comb begin
    d0    = W'(signed'(place_i[CoordBits-1:0]));
    dstsz = W'(dst_size_i[CoordBits-1:0]);
    if (d0 < 0) begin
      s2  = s1_q - d0;
      dw1 = w1_q + d0;
      d1  = '0;
    end else begin
      s2  = s1_q;
      dw1 = w1_q;
      d1  = d0;
    end
    sum2 = d1 + dw1;
    dw2  = (sum2 > dstsz) ? dstsz - d1 : dw1;
  end

  always_comb begin
    end3 = s2_q + dw2_q;
    ofs3 = d2_q + (p2_q - s2_q);
    hit3 = ok2_q && (p2_q >= s2_q) && (p2_q < end3);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_q  <= s1;
      w1_q  <= w2;
      ok1_q <= (w2 > 0);
      p1_q  <= W'(coord_i[CoordBits-1:0]);
    end
    if (en_i[1]) begin
      s2_q  <= s2;
      dw2_q <= dw2;
      d2_q  <= d1;
      ok2_q <= ok1_q && (dw2 > 0);
      p2_q  <= p1_q;
    end
    if (en_i[2]) begin
      res_q.hit <= hit3;
      res_q.dst <= hit3 ? CoordW'(ofs3[CoordBits-1:0]) : '0;
    end
  end

  assign res_o = res_q;

endmodule
